[design/madt_cpu_table_parser_core_macros.svh]
// assertion macros for the madt cpu table parser checker
// no dependencies; included by the checker file only
`ifndef MADT_CPU_TABLE_PARSER_CORE_MACROS_SVH
`define MADT_CPU_TABLE_PARSER_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define MADT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define MADT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[design/madt_pkg.sv]
// shared types and constants for the madt cpu table parser
// no dependencies; used by every module of the block
package madt_pkg;

	// cpu table geometry, fixed by the result field widths
	localparam int CPU_SLOTS = 16;
	localparam int SLOT_W    = 4;
	localparam int CNT_W     = 5;

	// header and record layout
	localparam logic [31:0] OFF_LEN_LO   = 32'd4;
	localparam logic [31:0] OFF_LEN_HI   = 32'd7;
	localparam logic [31:0] OFF_BASE_LO  = 32'd36;
	localparam logic [31:0] OFF_BASE_HI  = 32'd39;
	localparam logic [31:0] OFF_HDR_LAST = 32'd43;
	localparam logic [31:0] OFF_REC      = 32'd44;
	localparam logic [7:0]  REC_PROC     = 8'd0;
	localparam logic [7:0]  REC_IO       = 8'd1;
	localparam logic [7:0]  PROC_MIN_LEN = 8'd8;
	localparam logic [7:0]  IO_MIN_LEN   = 8'd12;
	localparam logic [7:0]  REC_MIN_LEN  = 8'd2;
	localparam logic [1:0]  CPU_EN_MASK  = 2'h3;

	// record field offsets
	localparam logic [7:0] RO_TYPE = 8'd0;
	localparam logic [7:0] RO_LEN  = 8'd1;
	localparam logic [7:0] RO_ID   = 8'd3;

	// result kinds
	localparam logic [2:0] KIND_LOCAL_BASE = 3'd0;
	localparam logic [2:0] KIND_CPU        = 3'd1;
	localparam logic [2:0] KIND_IO_ADDR    = 3'd2;
	localparam logic [2:0] KIND_TABLE_END  = 3'd3;
	localparam logic [2:0] KIND_ONLINE     = 3'd4;

	typedef struct packed {
		logic       command;
		logic [7:0] data_byte;
		logic       first_byte;
		logic [7:0] apic_id;
	} req_t;

	typedef struct packed {
		logic [2:0]       kind;
		logic [31:0]      value;
		logic [SLOT_W-1:0] slot;
		logic             found;
		logic [CNT_W-1:0] proc_total;
		logic [CNT_W-1:0] online_count;
		logic             last;
	} rsp_t;

	// write side of the result queue
	typedef struct packed {
		logic [1:0] num;
		rsp_t       first;
		rsp_t       second;
	} push_t;

endpackage

[design/madt_out_fifo.sv]
// four-entry result queue taking up to two items per cycle, handing out one
// depends on madt_pkg
module madt_out_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  madt_pkg::push_t     push,
	output logic                room2,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output madt_pkg::rsp_t      rsp
);
	import madt_pkg::*;

	rsp_t       mem_q [4];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] cnt_q;
	logic       pop;

	assign rsp_valid = (cnt_q != 3'd0);
	assign rsp       = mem_q[rd_q];
	assign pop       = rsp_valid && rsp_ready;
	assign room2     = (cnt_q <= 3'd2);

	// storage
	always_ff @(posedge clk) begin
		if (push.num != 2'd0) begin
			mem_q[wr_q] <= push.first;
		end
		if (push.num == 2'd2) begin
			mem_q[wr_q + 2'd1] <= push.second;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 2'd0;
			rd_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			wr_q  <= wr_q + push.num;
			rd_q  <= rd_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, push.num} - {2'b00, pop};
		end
	end

endmodule

[design/madt_cpu_table_parser_core.sv]
// channel | signals                    | item
// req     | req_valid, req_ready, req  | table byte or mark-online command
// rsp     | rsp_valid, rsp_ready, rsp  | one result, last marks the final one of an item
//
// one item is taken per cycle; its results land in a four-entry queue on the same edge
// the queue needs room for two results to take an item, so req stalls while three
// or more results wait
// an item giving two results needs two rsp transfers, which sets the sustained rate
// reset idles the parser until a byte with first_byte set; the cpu table starts empty
//
// top level of the madt cpu table parser; depends on madt_pkg and madt_out_fifo
module madt_cpu_table_parser_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  madt_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output madt_pkg::rsp_t rsp
);
	import madt_pkg::*;

	// parser state
	logic [31:0]       off_q, off_d;
	logic [31:0]       tl_q, tl_d;
	logic [7:0]        ro_q, ro_d;
	logic [7:0]        rl_q, rl_d;
	logic [7:0]        rt_q, rt_d;
	logic [31:0]       fs_q, fs_d;
	logic [7:0]        rid_q, rid_d;
	logic              done_q, done_d;
	logic [CNT_W-1:0]  rc_q, rc_d;
	logic [CNT_W-1:0]  onl_q, onl_d;
	logic [7:0]        ids_q [CPU_SLOTS];
	logic [CPU_SLOTS-1:0] flag_q;

	logic              accept;
	logic              room2;
	logic              clear_flags;
	logic              rec_we;
	logic              mark_we;
	logic              got;
	logic [SLOT_W-1:0] hit;
	push_t             push;

	assign req_ready = room2;
	assign accept    = req_valid && req_ready;

	// first matching id among recorded entries
	always_comb begin
		got = 1'b0;
		hit = '0;
		for (int i = CPU_SLOTS - 1; i >= 0; i--) begin
			if ((CNT_W'(i) < rc_q) && (ids_q[i] == req.apic_id)) begin
				got = 1'b1;
				hit = SLOT_W'(i);
			end
		end
	end

	// next state and results for one item
	always_comb begin
		logic [31:0] o;
		logic [7:0]  b;
		logic        stop;
		logic        has_first;
		rsp_t        first_r;
		rsp_t        end_r;

		off_d = off_q;
		tl_d  = tl_q;
		ro_d  = ro_q;
		rl_d  = rl_q;
		rt_d  = rt_q;
		fs_d  = fs_q;
		rid_d = rid_q;
		done_d = done_q;
		rc_d  = rc_q;
		onl_d = onl_q;
		clear_flags = 1'b0;
		rec_we  = 1'b0;
		mark_we = 1'b0;
		stop      = 1'b0;
		has_first = 1'b0;
		first_r   = '0;
		end_r     = '0;
		push      = '0;
		o = '0;
		b = req.data_byte;

		if (req.command) begin
			// mark online by id
			mark_we = got;
			if (got && !flag_q[hit]) begin
				onl_d = onl_q + CNT_W'(1);
			end
			first_r.kind         = KIND_ONLINE;
			first_r.slot         = hit;
			first_r.found        = got;
			first_r.proc_total   = rc_q;
			first_r.online_count = onl_d;
			first_r.last         = 1'b1;
			push.num   = 2'd1;
			push.first = first_r;
		end else if (req.first_byte || !done_q) begin
			// a new table clears everything before the byte is parsed
			if (req.first_byte) begin
				off_d = '0;
				tl_d  = '0;
				ro_d  = '0;
				rl_d  = '0;
				rt_d  = '0;
				fs_d  = '0;
				rid_d = '0;
				rc_d  = '0;
				onl_d = '0;
				clear_flags = 1'b1;
				done_d = 1'b0;
			end
			o = off_d;

			if (o inside {[OFF_LEN_LO:OFF_LEN_HI]}) begin
				// table length, little-endian
				tl_d[{o[1:0], 3'b000} +: 8] = tl_d[{o[1:0], 3'b000} +: 8] | b;
			end else if (o inside {[OFF_BASE_LO:OFF_BASE_HI]}) begin
				// local controller base
				if (o == OFF_BASE_LO) begin
					fs_d = '0;
				end
				fs_d[{o[1:0], 3'b000} +: 8] = fs_d[{o[1:0], 3'b000} +: 8] | b;
				if (o == OFF_BASE_HI) begin
					has_first       = 1'b1;
					first_r.kind    = KIND_LOCAL_BASE;
					first_r.value   = fs_d;
				end
			end else if (o >= OFF_REC) begin
				// record walk
				if (ro_d == RO_TYPE) begin
					rt_d  = b;
					fs_d  = '0;
					rid_d = '0;
				end else if (ro_d == RO_LEN) begin
					rl_d = b;
					stop = (b < REC_MIN_LEN);
				end else if (ro_d == RO_ID) begin
					rid_d = b;
				end else if (ro_d inside {[8'd4:8'd7]}) begin
					fs_d[{ro_d[1:0], 3'b000} +: 8] = fs_d[{ro_d[1:0], 3'b000} +: 8] | b;
				end
				if (!stop) begin
					if ((ro_d != RO_TYPE) && (ro_d + 8'd1 == rl_d)) begin
						// last byte of the record
						if ((rt_d == REC_PROC) && (rl_d >= PROC_MIN_LEN) &&
						    ((fs_d[1:0] & CPU_EN_MASK) != 2'b00) &&
						    (rc_d < CNT_W'(CPU_SLOTS))) begin
							rec_we          = 1'b1;
							has_first       = 1'b1;
							first_r.kind    = KIND_CPU;
							first_r.value   = {24'd0, rid_d};
							first_r.slot    = rc_d[SLOT_W-1:0];
							rc_d            = rc_d + CNT_W'(1);
						end else if ((rt_d == REC_IO) && (rl_d >= IO_MIN_LEN)) begin
							has_first       = 1'b1;
							first_r.kind    = KIND_IO_ADDR;
							first_r.value   = fs_d;
						end
						ro_d = '0;
					end else begin
						ro_d = ro_d + 8'd1;
					end
				end
			end

			// end of table
			if (!stop && (o >= OFF_HDR_LAST) &&
			    (({1'b0, o} + 33'd1) >= {1'b0, tl_d})) begin
				stop = 1'b1;
			end
			if (stop) begin
				done_d = 1'b1;
			end else begin
				off_d = o + 32'd1;
			end

			first_r.proc_total   = rc_d;
			first_r.online_count = onl_d;
			end_r.kind           = KIND_TABLE_END;
			end_r.proc_total     = rc_d;
			end_r.online_count   = onl_d;
			end_r.last           = 1'b1;
			first_r.last         = !stop;

			if (has_first) begin
				push.first = first_r;
				push.second = end_r;
				push.num   = stop ? 2'd2 : 2'd1;
			end else if (stop) begin
				push.first = end_r;
				push.num   = 2'd1;
			end
		end

		if (!accept) begin
			push.num = 2'd0;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q  <= '0;
			tl_q   <= '0;
			ro_q   <= '0;
			rl_q   <= '0;
			rt_q   <= '0;
			fs_q   <= '0;
			rid_q  <= '0;
			done_q <= 1'b1;
			rc_q   <= '0;
			onl_q  <= '0;
			flag_q <= '0;
		end else if (accept) begin
			off_q  <= off_d;
			tl_q   <= tl_d;
			ro_q   <= ro_d;
			rl_q   <= rl_d;
			rt_q   <= rt_d;
			fs_q   <= fs_d;
			rid_q  <= rid_d;
			done_q <= done_d;
			rc_q   <= rc_d;
			onl_q  <= onl_d;
			if (clear_flags) begin
				flag_q <= '0;
			end else if (rec_we) begin
				flag_q[rc_q[SLOT_W-1:0]] <= 1'b0;
			end else if (mark_we) begin
				flag_q[hit] <= 1'b1;
			end
		end
	end

	// cpu id table, only entries below the count are ever read
	always_ff @(posedge clk) begin
		if (accept && rec_we) begin
			ids_q[rc_d[SLOT_W-1:0] - SLOT_W'(1)] <= rid_d;
		end
	end

	madt_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room2     (room2),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

[design/madt_chk.sv]
// port-level checks for the madt cpu table parser, bound to the top level
// depends on madt_pkg and madt_cpu_table_parser_core_macros.svh
`include "madt_cpu_table_parser_core_macros.svh"

module madt_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input madt_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input madt_pkg::rsp_t rsp
);
	import madt_pkg::*;

	// a pending item is not withdrawn by the block
	`MADT_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)

	// an online command into an empty queue is answered on the next cycle
	`MADT_ASSERT_NEXT(a_online_reply, clk, arst_n, req_valid && req_ready && req.command && !rsp_valid, rsp_valid && (rsp.kind == KIND_ONLINE) && rsp.last)

	// online count never exceeds the recorded count, nor the recorded count the slot count
	`MADT_ASSERT_NOW(a_counts, clk, arst_n, rsp_valid, (rsp.online_count <= rsp.proc_total) && (rsp.proc_total <= CNT_W'(CPU_SLOTS)))

	// a table end result always closes its item
	`MADT_ASSERT_NOW(a_end_last, clk, arst_n, rsp_valid && (rsp.kind == KIND_TABLE_END), rsp.last)

endmodule

bind madt_cpu_table_parser_core madt_chk u_chk (.*);

[dv/madt_cpu_table_parser_core_tb.sv]
// self-checking bench for madt_cpu_table_parser_core: streams interrupt controller tables
// and mark-online commands, predicts every result in-bench and compares field by field
// depends on madt_pkg and the madt_cpu_table_parser_core rtl
module madt_cpu_table_parser_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import madt_pkg::*;

	localparam int CYCLE_LIMIT = 100000;
	localparam int END_WAIT    = 20;
	localparam int STALL_AT    = 400;
	localparam int STALL_LEN   = 150;

	typedef enum int {
		SHAPE_PLAIN,
		SHAPE_FULL,
		SHAPE_SHORT,
		SHAPE_BAD_LEN,
		SHAPE_CUT,
		SHAPE_OPEN
	} table_shape_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	req_t stream_items [$];
	rsp_t predicted_reports [$];
	rsp_t want;
	logic req_took = 1'b0;
	int items_queued = 0;
	int items_taken = 0;
	int cycle_count = 0;
	int fail_count = 0;
	int hold_left = 0;
	logic hold_done = 1'b0;

	// parser state mirror
	logic [31:0] tbl_pos = '0;
	logic [31:0] tbl_len = '0;
	logic [31:0] field_acc = '0;
	logic [7:0] rec_pos = '0;
	logic [7:0] rec_len = '0;
	logic [7:0] rec_kind = '0;
	logic [7:0] rec_apic = '0;
	logic parser_idle = 1'b1;
	int cpu_total = 0;
	logic [7:0] cpu_ids [CPU_SLOTS];
	logic [CPU_SLOTS-1:0] cpu_up = '0;

	madt_cpu_table_parser_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	// clock
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// result snapshot with the current counts
	function automatic rsp_t make_result(logic [2:0] kind, logic [31:0] value, int slot,
		logic found);
		rsp_t r;
		int up;
		up = 0;
		for (int i = 0; i < CPU_SLOTS; i++)
			if (i < cpu_total && cpu_up[i])
				up++;
		r.kind = kind;
		r.value = value;
		r.slot = 4'(slot);
		r.found = found;
		r.proc_total = 5'(cpu_total);
		r.online_count = 5'(up);
		r.last = 1'b0;
		return r;
	endfunction

	// advance the parser mirror by one item and queue the results it causes
	task automatic parse_step(input req_t it);
		rsp_t outs [2];
		rsp_t r;
		int n;
		int hit;
		logic stop;
		logic [31:0] pos;
		logic [7:0] b;
		logic [7:0] rp;
		n = 0;
		hit = -1;
		stop = 1'b0;
		if (it.command) begin
			// first matching entry wins
			for (int i = 0; i < CPU_SLOTS; i++)
				if (hit < 0 && i < cpu_total && cpu_ids[i] == it.apic_id)
					hit = i;
			if (hit >= 0)
				cpu_up[hit] = 1'b1;
			outs[0] = make_result(KIND_ONLINE, '0, (hit >= 0) ? hit : 0, hit >= 0);
			n = 1;
		end else begin
			if (it.first_byte) begin
				tbl_pos = '0;
				tbl_len = '0;
				rec_pos = '0;
				rec_len = '0;
				rec_kind = '0;
				field_acc = '0;
				rec_apic = '0;
				cpu_total = 0;
				cpu_up = '0;
				parser_idle = 1'b0;
			end
			if (!parser_idle) begin
				pos = tbl_pos;
				b = it.data_byte;
				if (pos >= OFF_LEN_LO && pos <= OFF_LEN_HI) begin
					tbl_len |= 32'(b) << (8 * (pos - OFF_LEN_LO));
				end else if (pos >= OFF_BASE_LO && pos <= OFF_BASE_HI) begin
					if (pos == OFF_BASE_LO)
						field_acc = '0;
					field_acc |= 32'(b) << (8 * (pos - OFF_BASE_LO));
					if (pos == OFF_BASE_HI) begin
						outs[n] = make_result(KIND_LOCAL_BASE, field_acc, 0, 1'b0);
						n++;
					end
				end else if (pos >= OFF_REC) begin
					rp = rec_pos;
					if (rp == RO_TYPE) begin
						rec_kind = b;
						field_acc = '0;
						rec_apic = '0;
					end else if (rp == RO_LEN) begin
						rec_len = b;
						if (b < REC_MIN_LEN)
							stop = 1'b1;
					end else if (rp == RO_ID) begin
						rec_apic = b;
					end else if (rp >= 8'd4 && rp <= 8'd7) begin
						field_acc |= 32'(b) << (8 * (rp - 8'd4));
					end
					if (!stop) begin
						// record complete on its last byte
						if (rp >= RO_LEN && int'(rp) + 1 == int'(rec_len)) begin
							if (rec_kind == REC_PROC && rec_len >= PROC_MIN_LEN &&
								(field_acc[1:0] & CPU_EN_MASK) != 2'b00 &&
								cpu_total < CPU_SLOTS) begin
								cpu_ids[cpu_total] = rec_apic;
								cpu_up[cpu_total] = 1'b0;
								cpu_total++;
								outs[n] = make_result(KIND_CPU, 32'(rec_apic), cpu_total - 1,
									1'b0);
								n++;
							end else if (rec_kind == REC_IO && rec_len >= IO_MIN_LEN) begin
								outs[n] = make_result(KIND_IO_ADDR, field_acc, 0, 1'b0);
								n++;
							end
							rec_pos = '0;
						end else begin
							rec_pos = rp + 8'd1;
						end
					end
				end
				if (!stop && pos >= OFF_HDR_LAST && {1'b0, pos} + 33'd1 >= {1'b0, tbl_len})
					stop = 1'b1;
				if (stop) begin
					parser_idle = 1'b1;
					outs[n] = make_result(KIND_TABLE_END, '0, 0, 1'b0);
					n++;
				end else begin
					tbl_pos = pos + 32'd1;
				end
			end
		end
		for (int k = 0; k < n; k++) begin
			r = outs[k];
			r.last = (k == n - 1);
			predicted_reports.push_back(r);
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] exp_val);
		if (got !== exp_val) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, got);
			fail_count++;
		end
	endtask

	// ids mostly from a small pool so commands hit recorded entries
	function automatic logic [7:0] pick_id();
		if ($urandom_range(0, 99) < 80)
			return 8'($urandom_range(0, 31));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic steady();
		return items_taken >= 100 && items_taken < 260;
	endfunction

	task automatic add_item(input logic cmd, input logic [7:0] data, input logic first,
		input logic [7:0] id);
		req_t it;
		it.command = cmd;
		it.data_byte = data;
		it.first_byte = first;
		it.apic_id = id;
		stream_items.push_back(it);
		items_queued++;
	endtask

	// build one table of the given shape with random content and queue its bytes
	task automatic add_table(input table_shape_e shape);
		logic [7:0] bytes [$];
		logic [31:0] word;
		logic [31:0] tlen;
		logic [7:0] rtype;
		logic [7:0] rlen;
		logic [7:0] rid;
		int nrec;
		int bad_at;
		int roll;
		for (int i = 0; i < 44; i++)
			bytes.push_back(8'($urandom));
		if (shape == SHAPE_FULL)
			nrec = $urandom_range(17, 20);
		else
			nrec = $urandom_range((shape == SHAPE_PLAIN) ? 0 : 1, 8);
		bad_at = (shape == SHAPE_BAD_LEN) ? $urandom_range(0, nrec - 1) : -1;
		for (int r = 0; r < nrec; r++) begin
			roll = $urandom_range(0, 99);
			word = $urandom;
			rid = pick_id();
			if (shape == SHAPE_FULL || roll < 50) begin
				rtype = REC_PROC;
				rlen = PROC_MIN_LEN;
				if (shape == SHAPE_FULL)
					word[0] = 1'b1;
				else if ($urandom_range(0, 99) < 30)
					word[1:0] = 2'b00;
			end else if (roll < 75) begin
				rtype = REC_IO;
				rlen = IO_MIN_LEN;
			end else begin
				rtype = 8'($urandom_range(2, 255));
				rlen = 8'($urandom_range(2, 10));
			end
			// short and padded records
			if (shape != SHAPE_FULL) begin
				roll = $urandom_range(0, 99);
				if (roll < 15 && rlen > 8'd2)
					rlen = 8'($urandom_range(2, rlen - 1));
				else if (roll >= 15 && roll < 30)
					rlen = rlen + 8'($urandom_range(1, 4));
			end
			if (r == bad_at)
				rlen = 8'($urandom_range(0, 1));
			for (int k = 0; k < ((rlen < REC_MIN_LEN) ? 4 : int'(rlen)); k++) begin
				if (k == 0)
					bytes.push_back(rtype);
				else if (k == 1)
					bytes.push_back(rlen);
				else if (k == 3)
					bytes.push_back(rid);
				else if (k >= 4 && k <= 7)
					bytes.push_back(word[8 * (k - 4) +: 8]);
				else
					bytes.push_back(8'($urandom));
			end
		end
		case (shape)
			SHAPE_SHORT: tlen = $urandom_range(0, 44);
			SHAPE_CUT:   tlen = bytes.size() - $urandom_range(1, 6);
			SHAPE_OPEN:  tlen = {8'($urandom_range(1, 255)), 24'($urandom)};
			default:     tlen = bytes.size();
		endcase
		for (int i = 0; i < 4; i++)
			bytes[OFF_LEN_LO + i] = tlen[8 * i +: 8];
		// stray online commands and the odd restart in mid-table
		foreach (bytes[i]) begin
			if ($urandom_range(0, 99) < 5)
				add_item(1'b1, 8'($urandom), 1'($urandom), pick_id());
			add_item(1'b0, bytes[i], i == 0 || $urandom_range(0, 499) == 0, 8'($urandom));
		end
	endtask

	// request driver
	always @(negedge clk) begin
		if (!req_valid || req_took) begin
			if (stream_items.size() != 0 && (steady() || $urandom_range(0, 99) >= 15)) begin
				req <= stream_items.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// result ready, with one long hold-off once the stream is well under way
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else if (!hold_done && items_taken >= STALL_AT) begin
			hold_done = 1'b1;
			hold_left = STALL_LEN;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= steady() || $urandom_range(0, 99) >= 15;
		end
	end

	// monitor: predict on each accepted item, check each accepted result
	always @(posedge clk) begin
		req_took <= req_valid && req_ready;
		if (arst_n) begin
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("madt_cpu_table_parser_core verification failed");
				$finish;
			end else begin
				if (req_valid && req_ready) begin
					parse_step(req);
					items_taken++;
				end
				if (rsp_valid && rsp_ready) begin
					if (predicted_reports.size() == 0) begin
						$display("%0t: unexpected result, expected none, got %h", $time, rsp);
						fail_count++;
					end else begin
						want = predicted_reports.pop_front();
						check_field("kind", 32'(rsp.kind), 32'(want.kind));
						check_field("value", rsp.value, want.value);
						check_field("slot", 32'(rsp.slot), 32'(want.slot));
						check_field("found", 32'(rsp.found), 32'(want.found));
						check_field("proc_total", 32'(rsp.proc_total), 32'(want.proc_total));
						check_field("online_count", 32'(rsp.online_count),
							32'(want.online_count));
						check_field("last", 32'(rsp.last), 32'(want.last));
					end
				end
			end
		end
	end

	// stimulus and end of run
	initial begin
		int t;
		t = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// idle bytes and online commands against an empty cpu table
		add_item(1'b0, 8'h00, 1'b0, 8'h00);
		add_item(1'b0, 8'hff, 1'b0, 8'hff);
		add_item(1'b1, 8'h00, 1'b0, 8'h00);
		add_item(1'b1, 8'hff, 1'b1, 8'hff);
		add_item(1'b0, 8'h5a, 1'b0, 8'h00);
		add_item(1'b1, 8'h00, 1'b0, 8'h1f);

		// sender holds until every result is back
		while (stream_items.size() != 0 || req_valid || predicted_reports.size() != 0)
			@(negedge clk);
		@(posedge clk);

		// random tables of every shape, commands and idle noise between them
		while (items_queued < 600) begin
			add_table(table_shape_e'(t % 6));
			repeat ($urandom_range(1, 4))
				add_item(1'b1, 8'($urandom), 1'($urandom), pick_id());
			repeat ($urandom_range(0, 3))
				add_item(1'b0, 8'($urandom), 1'b0, 8'($urandom));
			t++;
		end

		while (stream_items.size() != 0 || req_valid || predicted_reports.size() != 0)
			@(negedge clk);
		repeat (END_WAIT) @(posedge clk);
		if (fail_count == 0)
			$display("madt_cpu_table_parser_core verification clean");
		else
			$display("madt_cpu_table_parser_core verification failed");
		$finish;
	end

endmodule
